/* rtl/assert_macros.svh */
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/knps_pkg.sv */
// Shared types and constants of the k-nearest point selector.
package knps_pkg;

  localparam int COORD_BITS = 16;
  localparam int INDEX_W    = 16;
  localparam int KEEP_W     = 4;
  localparam int DIST_W     = COORD_BITS + 1;
  localparam int SQ_W       = 2 * COORD_BITS + 1;
  localparam int CFG_W      = COORD_BITS;
  localparam int CFG_IDX_W  = 2;

  localparam int DEFAULT_MAX_KEEP    = 8;
  localparam int DEFAULT_QUEUE_DEPTH = 4;

  localparam logic [INDEX_W-1:0] INDEX_MAX  = {INDEX_W{1'b1}};
  localparam logic [KEEP_W-1:0]  KEEP_RESET = KEEP_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUERY_X    = 2'd0,
    CFG_QUERY_Y    = 2'd1,
    CFG_KEEP_COUNT = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic                         last_point;
  } point_t;

  typedef struct packed {
    logic [DIST_W-1:0]  distance;
    logic [INDEX_W-1:0] point_index;
    logic               last_result;
  } result_t;

  // One measured point on its way from the front end to the selector.
  typedef struct packed {
    logic [SQ_W-1:0]    sq;
    logic [INDEX_W-1:0] index;
    logic               last;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_status_t;

endpackage

/* rtl/knps_front.sv */
// Front end: number each point and compute its squared distance in three stages.
module knps_front
  import knps_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  point_t                       point,
  input  logic signed [COORD_BITS-1:0] query_x,
  input  logic signed [COORD_BITS-1:0] query_y,
  output logic                         push,
  output entry_t                       entry
);

  logic [INDEX_W-1:0]           next_index;
  logic                         v1, v2, v3;
  logic [COORD_BITS-1:0]        dx1, dy1;
  logic [2*COORD_BITS-1:0]      dx2, dy2;
  logic [INDEX_W-1:0]           idx1, idx2;
  logic                         last1, last2;
  logic signed [COORD_BITS:0]   dxs, dys;

  always_comb begin
    dxs = (COORD_BITS+1)'(point.point_x) - (COORD_BITS+1)'(query_x);
    dys = (COORD_BITS+1)'(point.point_y) - (COORD_BITS+1)'(query_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_index <= '0;
      v1         <= 1'b0;
      v2         <= 1'b0;
      v3         <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
      if (accept) begin
        // restart numbering after the last point, saturate otherwise
        if (point.last_point) begin
          next_index <= '0;
        end else if (next_index != INDEX_MAX) begin
          next_index <= next_index + INDEX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    dx1   <= COORD_BITS'(dxs[COORD_BITS] ? -dxs : dxs);
    dy1   <= COORD_BITS'(dys[COORD_BITS] ? -dys : dys);
    idx1  <= next_index;
    last1 <= point.last_point;
    dx2   <= (2*COORD_BITS)'(dx1) * (2*COORD_BITS)'(dx1);
    dy2   <= (2*COORD_BITS)'(dy1) * (2*COORD_BITS)'(dy1);
    idx2  <= idx1;
    last2 <= last1;
    entry.sq    <= SQ_W'(dx2) + SQ_W'(dy2);
    entry.index <= idx2;
    entry.last  <= last2;
  end

  assign push = v3;

endmodule

/* rtl/knps_fifo.sv */
// Short queue between the front end and the selector.
module knps_fifo
  import knps_pkg::*;
#(
  parameter int DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  entry_t       wdata,
  input  logic         pop,
  output entry_t       rdata,
  output fifo_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             mem [DEPTH];
  logic [PTR_W-1:0]   wptr, rptr;
  logic [CNT_W-1:0]   count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + PTR_W'(1);
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  assign rdata        = mem[rptr];
  assign status.empty = (count == '0);
  assign status.full  = (count == CNT_W'(DEPTH));

endmodule

/* rtl/knps_isqrt.sv */
// Floor square root, one result bit per cycle.
module knps_isqrt
  import knps_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SQ_W-1:0]   operand,
  output logic              done,
  output logic [DIST_W-1:0] root
);

  localparam int N     = DIST_W;
  localparam int VW    = 2 * N;
  localparam int CNT_W = $clog2(N + 1);

  logic [VW-1:0]    val;
  logic [N+1:0]     rem, rem_next, rem_sh, trial;
  logic [N-1:0]     root_next;
  logic [CNT_W-1:0] count;
  logic             running;

  always_comb begin
    rem_sh = {rem[N-1:0], val[VW-1:VW-2]};
    trial  = {root, 2'b01};
    if (rem_sh >= trial) begin
      rem_next  = rem_sh - trial;
      root_next = {root[N-2:0], 1'b1};
    end else begin
      rem_next  = rem_sh;
      root_next = {root[N-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        count   <= CNT_W'(N);
      end else if (running) begin
        count <= count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val  <= VW'(operand);
      rem  <= '0;
      root <= '0;
    end else if (running) begin
      val  <= val << 2;
      rem  <= rem_next;
      root <= root_next;
    end
  end

endmodule

/* rtl/knps_back.sv */
// Selector: ordered insert of each point into the kept list, then ranked emission.
module knps_back
  import knps_pkg::*;
#(
  parameter int MAX_KEEP = DEFAULT_MAX_KEEP
) (
  input  logic               clk,
  input  logic               rst,
  input  entry_t             entry,
  input  fifo_status_t       fifo_status,
  input  logic [KEEP_W-1:0]  keep_count,
  output logic               pop,
  output logic               result_valid,
  output result_t            result
);

  localparam int FILL_W = $clog2(MAX_KEEP + 1);
  localparam int IDX_W  = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
  localparam int CMP_W  = (FILL_W > KEEP_W) ? FILL_W : KEEP_W;

  typedef enum logic [2:0] {
    S_RUN  = 3'b001,
    S_LOAD = 3'b010,
    S_ROOT = 3'b100
  } state_t;

  state_t               state;
  logic [SQ_W-1:0]      ks [MAX_KEEP];
  logic [INDEX_W-1:0]   ki [MAX_KEEP];
  logic [SQ_W-1:0]      ks_next [MAX_KEEP];
  logic [INDEX_W-1:0]   ki_next [MAX_KEEP];
  logic [FILL_W-1:0]    fill, fill_next;
  logic [IDX_W-1:0]     ptr, skip;
  logic [MAX_KEEP:0]    gt;
  logic [MAX_KEEP-1:0]   sel_a, sel_b;
  logic [CMP_W-1:0]     k_raw, k_eff;
  logic                 do_ins, do_rep, write_list, last_res;
  logic                 sqrt_done;
  logic [DIST_W-1:0]    sqrt_root;

  // gt[j]: the new point ranks ahead of entry j (empty slots rank last)
  always_comb begin
    gt = '1;
    for (int j = 0; j < MAX_KEEP; j++) begin
      if (FILL_W'(j) < fill) begin
        gt[j] = (entry.sq > ks[j]) || ((entry.sq == ks[j]) && (entry.index > ki[j]));
      end
    end
  end

  always_comb begin
    k_raw = CMP_W'(keep_count);
    if (k_raw == '0) begin
      k_eff = CMP_W'(1);
    end else if (k_raw > CMP_W'(MAX_KEEP)) begin
      k_eff = CMP_W'(MAX_KEEP);
    end else begin
      k_eff = k_raw;
    end
    do_ins = (CMP_W'(fill) < k_eff) && (fill < FILL_W'(MAX_KEEP));
    do_rep = !do_ins && (fill != '0) && (entry.sq < ks[0]);
  end

  // Shift-insert: on a replacement the list moves up one slot first.
  always_comb begin
    for (int j = 0; j < MAX_KEEP; j++) begin
      if (do_rep) begin
        sel_a[j] = gt[j+1];
        sel_b[j] = (j == 0) ? 1'b0 : gt[j];
      end else begin
        sel_a[j] = gt[j];
        sel_b[j] = (j == 0) ? 1'b0 : gt[(j == 0) ? 0 : j-1];
      end
    end
    for (int j = 0; j < MAX_KEEP; j++) begin
      ks_next[j] = ks[j];
      ki_next[j] = ki[j];
      if (!sel_a[j]) begin
        if (do_rep && (j < MAX_KEEP - 1)) begin
          ks_next[j] = ks[(j < MAX_KEEP - 1) ? j+1 : j];
          ki_next[j] = ki[(j < MAX_KEEP - 1) ? j+1 : j];
        end
      end else if (!sel_b[j]) begin
        ks_next[j] = entry.sq;
        ki_next[j] = entry.index;
      end else if (!do_rep && (j > 0)) begin
        ks_next[j] = ks[(j > 0) ? j-1 : j];
        ki_next[j] = ki[(j > 0) ? j-1 : j];
      end
    end
  end

  always_comb begin
    fill_next = do_ins ? fill + FILL_W'(1) : fill;
    skip      = (CMP_W'(fill_next) > k_eff) ? IDX_W'(CMP_W'(fill_next) - k_eff) : '0;
    pop       = (state == S_RUN) && !fifo_status.empty;
    write_list = pop && (do_ins || do_rep);
    last_res  = (FILL_W'(ptr) + FILL_W'(1)) == fill;
  end

  always_ff @(posedge clk) begin
    if (write_list) begin
      for (int j = 0; j < MAX_KEEP; j++) begin
        ks[j] <= ks_next[j];
        ki[j] <= ki_next[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_RUN;
      fill         <= '0;
      ptr          <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_RUN: begin
          if (pop) begin
            fill <= fill_next;
            if (entry.last) begin
              ptr   <= skip;
              state <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          state <= S_ROOT;
        end
        S_ROOT: begin
          if (sqrt_done) begin
            result_valid <= 1'b1;
            if (last_res) begin
              fill  <= '0;
              state <= S_RUN;
            end else begin
              ptr   <= ptr + IDX_W'(1);
              state <= S_LOAD;
            end
          end
        end
        default: begin
          state <= S_RUN;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (sqrt_done) begin
      result.distance    <= sqrt_root;
      result.point_index <= ki[ptr];
      result.last_result <= last_res;
    end
  end

  knps_isqrt u_isqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (state == S_LOAD),
    .operand (ks[ptr]),
    .done    (sqrt_done),
    .root    (sqrt_root)
  );

endmodule

/* rtl/k_nearest_point_select.sv */
// Top level of the streaming k-nearest point selector.
//
// Points are taken on start while busy is low, at most one per cycle, and
// numbered from 0 in arrival order within a set. A three-stage front end forms
// the exact squared distance to the query point and hands it through a short
// queue to the selector, which, while it is not emitting results, folds one
// point per cycle into a sorted list of at most MAX_KEEP entries. Accepted
// points in flight (front end plus queue) are capped at QUEUE_DEPTH; busy is
// high while that many are outstanding and falls only in the cycle after the
// selector takes one, so even a steady stream at the default depth of four
// sees busy rise at times. The point marked last_point triggers emission of
// min(keep_count, points) results, a keep_count of zero counting as one and
// one above MAX_KEEP as MAX_KEEP, farthest first, equal distances larger
// index first. Each result needs a floor square root that resolves one bit
// per cycle; the selector takes each result through S_LOAD and then S_ROOT
// and folds in no new points until the last result is out; the
// front end keeps taking points meanwhile until the queue fills. Each result
// is held on result for exactly one cycle with result_valid high; the
// receiver cannot stall it, so it must take every result as it appears.
// Write configuration (query_x, query_y, keep_count) only while the block is
// idle. Reset clears no memory: there is no clearing pass.
`include "assert_macros.svh"

module k_nearest_point_select
  import knps_pkg::*;
#(
  parameter int MAX_KEEP    = DEFAULT_MAX_KEEP,
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  point_t               point,
  output logic                 busy,
  output logic                 result_valid,
  output result_t              result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int CREDIT_W = $clog2(QUEUE_DEPTH + 1);

  logic signed [COORD_BITS-1:0] query_x, query_y;
  logic [KEEP_W-1:0]            keep_count;
  logic [CREDIT_W-1:0]          credit;
  logic                         accept, push, pop;
  entry_t                       front_entry, queue_entry;
  fifo_status_t                 fifo_status;

  // Configuration registers; unused index is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      query_x    <= '0;
      query_y    <= '0;
      keep_count <= KEEP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_QUERY_X:    query_x    <= cfg_data[COORD_BITS-1:0];
        CFG_QUERY_Y:    query_y    <= cfg_data[COORD_BITS-1:0];
        CFG_KEEP_COUNT: keep_count <= cfg_data[KEEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Count items accepted but not yet taken by the selector, so the queue
  // always has room for whatever the front end still carries.
  assign accept = start && !busy;
  assign busy   = (credit == CREDIT_W'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      credit <= '0;
    end else if (accept && !pop) begin
      credit <= credit + CREDIT_W'(1);
    end else if (pop && !accept) begin
      credit <= credit - CREDIT_W'(1);
    end
  end

  knps_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .point   (point),
    .query_x (query_x),
    .query_y (query_y),
    .push    (push),
    .entry   (front_entry)
  );

  knps_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wdata  (front_entry),
    .pop    (pop),
    .rdata  (queue_entry),
    .status (fifo_status)
  );

  knps_back #(
    .MAX_KEEP (MAX_KEEP)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .entry        (queue_entry),
    .fifo_status  (fifo_status),
    .keep_count   (keep_count),
    .pop          (pop),
    .result_valid (result_valid),
    .result       (result)
  );

  // Credit accounting must keep the queue from overflowing.
  `ASSERT_ALWAYS(a_credit_bound, credit <= CREDIT_W'(QUEUE_DEPTH), "credit above queue depth")
  `ASSERT_IMPLIES(a_push_room, push, !fifo_status.full, "push into full queue")
  `ASSERT_IMPLIES(a_pop_item, pop, !fifo_status.empty, "pop from empty queue")
  // The square root unit spaces results apart.
  `ASSERT_NEXT(a_result_gap, result_valid, !result_valid, "results back to back")

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench of the k-nearest point selector.
module tb;
  import knps_pkg::*;

  // Largest kept list; keep_count above this acts as this.
  localparam int KEEP_LIMIT = DEFAULT_MAX_KEEP;
  // Front end, queue and selector drain well within this after the last result.
  localparam int SETTLE_CYCLES = 40;
  // Cycle limit for the whole run, set far above what a correct run needs.
  localparam int LIMIT_CYCLES = 3_000_000;
  // Random items per idle mode.
  localparam int ITEMS_PER_MODE = 125;
  // Register index with no register behind it; a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef result_t result_q_t[$];
  typedef enum logic {ROW_POINT, ROW_REG} row_kind_e;

  // One row of the directed part: a register write or a point item.
  // When typed is set, want is the one result the item must cause.
  typedef struct {
    row_kind_e              kind;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [CFG_W-1:0]       reg_data;
    point_t                 pt;
    bit                     typed;
    result_t                want;
  } drill_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  point_t               point = '0;
  logic                 busy;
  logic                 result_valid;
  result_t              result;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // Shadow of the configuration registers, updated as each write lands.
  logic [CFG_W-1:0]  query_x_q = '0;
  logic [CFG_W-1:0]  query_y_q = '0;
  logic [KEEP_W-1:0] keep_q = KEEP_RESET;

  // Shadow of the kept list: farthest first, equal distances larger index first.
  logic [SQ_W-1:0]    near_sq[KEEP_LIMIT];
  logic [INDEX_W-1:0] near_idx[KEEP_LIMIT];
  int                 near_fill = 0;
  logic [INDEX_W-1:0] next_idx = '0;

  // Results still owed by the block, oldest first.
  result_t expected_results[$];
  result_t oldest;

  int idle_pct = 0;
  int fail_count = 0;
  int items_sent = 0;
  int results_seen = 0;
  int sets_closed = 0;

  k_nearest_point_select i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .point        (point),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Directed part. Query is (0,0) and keep_count 1 out of reset. Coordinates
  // are raw Q12.4 words. Rows with a typed result can be checked by hand;
  // the rest go through the predictor.
  drill_row_t drill[$] = '{
    // point on the query itself: distance 0
    '{ROW_POINT, CFG_QUERY_X, 16'h0000, '{16'sh0000, 16'sh0000, 1'b1}, 1'b1,
      '{17'd0, 16'd0, 1'b1}},
    // most negative corner against the origin: floor(sqrt(2^31))
    '{ROW_POINT, CFG_QUERY_X, 16'h0000, '{16'sh8000, 16'sh8000, 1'b1}, 1'b1,
      '{17'd46340, 16'd0, 1'b1}},
    '{ROW_POINT, CFG_QUERY_X, 16'h0000, '{16'sh7FFF, 16'sh8000, 1'b1}, 1'b0, '0},
    // two-point set with a single slot: the nearer one wins
    '{ROW_POINT, CFG_QUERY_X, 16'h0000, '{16'sh8000, 16'sh7FFF, 1'b0}, 1'b0, '0},
    '{ROW_POINT, CFG_QUERY_X, 16'h0000, '{16'sd5, -16'sd3, 1'b1}, 1'b0, '0},
    // query at the far corner, point at the opposite one: largest distance
    '{ROW_REG, CFG_QUERY_X, 16'h7FFF, '0, 1'b0, '0},
    '{ROW_REG, CFG_QUERY_Y, 16'h7FFF, '0, 1'b0, '0},
    '{ROW_REG, CFG_KEEP_COUNT, 16'd8, '0, 1'b0, '0},
    '{ROW_POINT, CFG_QUERY_X, 16'h0000, '{16'sh8000, 16'sh8000, 1'b1}, 1'b1,
      '{17'd92680, 16'd0, 1'b1}},
    // query (16,-16); four points at equal distance test the tie order
    '{ROW_REG, CFG_QUERY_X, 16'd16, '0, 1'b0, '0},
    '{ROW_REG, CFG_QUERY_Y, 16'hFFF0, '0, 1'b0, '0},
    '{ROW_POINT, CFG_QUERY_X, 16'h0000, '{16'sd21, -16'sd16, 1'b0}, 1'b0, '0},
    '{ROW_POINT, CFG_QUERY_X, 16'h0000, '{16'sd11, -16'sd16, 1'b0}, 1'b0, '0},
    '{ROW_POINT, CFG_QUERY_X, 16'h0000, '{16'sd16, -16'sd11, 1'b0}, 1'b0, '0},
    '{ROW_POINT, CFG_QUERY_X, 16'h0000, '{16'sd19, -16'sd12, 1'b0}, 1'b0, '0},
    '{ROW_POINT, CFG_QUERY_X, 16'h0000, '{16'sd16, -16'sd16, 1'b0}, 1'b0, '0},
    '{ROW_POINT, CFG_QUERY_X, 16'h0000, '{16'sd116, -16'sd16, 1'b1}, 1'b0, '0},
    // three slots: a tie with the farthest kept point must not replace it,
    // a strictly nearer point must
    '{ROW_REG, CFG_KEEP_COUNT, 16'd3, '0, 1'b0, '0},
    '{ROW_POINT, CFG_QUERY_X, 16'h0000, '{16'sd26, -16'sd16, 1'b0}, 1'b0, '0},
    '{ROW_POINT, CFG_QUERY_X, 16'h0000, '{16'sd16, -16'sd6, 1'b0}, 1'b0, '0},
    '{ROW_POINT, CFG_QUERY_X, 16'h0000, '{16'sd23, -16'sd16, 1'b0}, 1'b0, '0},
    '{ROW_POINT, CFG_QUERY_X, 16'h0000, '{16'sd6, -16'sd16, 1'b0}, 1'b0, '0},
    '{ROW_POINT, CFG_QUERY_X, 16'h0000, '{16'sd16, -16'sd22, 1'b1}, 1'b0, '0},
    // keep_count lowered in the middle of a set: only the nearest are emitted
    '{ROW_REG, CFG_KEEP_COUNT, 16'd4, '0, 1'b0, '0},
    '{ROW_POINT, CFG_QUERY_X, 16'h0000, '{16'sd46, -16'sd16, 1'b0}, 1'b0, '0},
    '{ROW_POINT, CFG_QUERY_X, 16'h0000, '{16'sd16, 16'sd4, 1'b0}, 1'b0, '0},
    '{ROW_POINT, CFG_QUERY_X, 16'h0000, '{16'sd6, -16'sd16, 1'b0}, 1'b0, '0},
    '{ROW_POINT, CFG_QUERY_X, 16'h0000, '{16'sd17, -16'sd15, 1'b0}, 1'b0, '0},
    '{ROW_REG, CFG_KEEP_COUNT, 16'd2, '0, 1'b0, '0},
    '{ROW_POINT, CFG_QUERY_X, 16'h0000, '{16'sd21, -16'sd16, 1'b0}, 1'b0, '0},
    '{ROW_POINT, CFG_QUERY_X, 16'h0000, '{16'sd19, -16'sd16, 1'b1}, 1'b0, '0},
    // keep_count zero acts as one
    '{ROW_REG, CFG_KEEP_COUNT, 16'd0, '0, 1'b0, '0},
    '{ROW_POINT, CFG_QUERY_X, 16'h0000, '{16'sd16, -16'sd14, 1'b0}, 1'b0, '0},
    '{ROW_POINT, CFG_QUERY_X, 16'h0000, '{16'sd16, -16'sd16, 1'b1}, 1'b0, '0},
    // keep_count above the list size acts as the list size; a write to the
    // spare index leaves the query where it was
    '{ROW_REG, CFG_KEEP_COUNT, 16'd15, '0, 1'b0, '0},
    '{ROW_REG, CFG_SPARE, 16'h1234, '0, 1'b0, '0},
    '{ROW_POINT, CFG_QUERY_X, 16'h0000, '{16'sd16, -16'sd16, 1'b1}, 1'b1,
      '{17'd0, 16'd0, 1'b1}}
  };

  // Append one result to the owed list.
  function automatic void owe_result(result_t r);
    expected_results = {expected_results, r};
  endfunction

  // Fold one accepted point into the shadow list; return the results it causes.
  function automatic result_q_t fold_point(point_t p);
    logic [COORD_BITS:0]   dx, dy, mag_x, mag_y;
    logic [SQ_W-1:0]       sq;
    logic [DIST_W-1:0]     root, trial;
    logic [2*DIST_W-1:0]   trial_sq;
    int                    k, pos, first, i, b;
    bit                    take;
    result_t               one;
    result_q_t             emitted;
    // exact squared distance from sign-extended differences
    dx = {p.point_x[COORD_BITS-1], p.point_x} - {query_x_q[COORD_BITS-1], query_x_q};
    dy = {p.point_y[COORD_BITS-1], p.point_y} - {query_y_q[COORD_BITS-1], query_y_q};
    mag_x = dx[COORD_BITS] ? -dx : dx;
    mag_y = dy[COORD_BITS] ? -dy : dy;
    sq = SQ_W'(mag_x) * SQ_W'(mag_x) + SQ_W'(mag_y) * SQ_W'(mag_y);
    // clamp keep_count into 1..list size
    k = (keep_q == 0) ? 1 : ((keep_q > KEEP_LIMIT) ? KEEP_LIMIT : int'(keep_q));
    take = near_fill < k;
    // full list: drop the farthest only for a strictly nearer point
    if (!take && near_fill > 0 && sq < near_sq[0]) begin
      for (i = 1; i < near_fill; i++) begin
        near_sq[i-1] = near_sq[i];
        near_idx[i-1] = near_idx[i];
      end
      near_fill--;
      take = 1'b1;
    end
    if (take) begin
      pos = near_fill;
      while (pos > 0 && (sq > near_sq[pos-1] ||
                         (sq == near_sq[pos-1] && next_idx > near_idx[pos-1]))) begin
        near_sq[pos] = near_sq[pos-1];
        near_idx[pos] = near_idx[pos-1];
        pos--;
      end
      near_sq[pos] = sq;
      near_idx[pos] = next_idx;
      near_fill++;
    end
    // hold the index at its ceiling
    if (next_idx != INDEX_MAX) next_idx++;
    if (p.last_point) begin
      first = (near_fill > k) ? near_fill - k : 0;
      for (i = first; i < near_fill; i++) begin
        // floor square root, one bit at a time from the top
        root = '0;
        for (b = DIST_W - 1; b >= 0; b--) begin
          trial = root | (DIST_W'(1) << b);
          trial_sq = (2*DIST_W)'(trial) * (2*DIST_W)'(trial);
          if (trial_sq <= (2*DIST_W)'(near_sq[i])) root = trial;
        end
        one.distance = root;
        one.point_index = near_idx[i];
        one.last_result = (i == near_fill - 1);
        emitted = {emitted, one};
      end
      near_fill = 0;
      next_idx = '0;
    end
    return emitted;
  endfunction

  // Coordinate near a center, at an extreme, or anywhere.
  function automatic logic [CFG_W-1:0] pick_coord(logic [CFG_W-1:0] center);
    case ($urandom_range(9))
      0, 1, 2: return CFG_W'($urandom);
      3:       return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
      4, 5, 6: return center + CFG_W'($urandom_range(16)) - 16'd8;
      default: return center + CFG_W'($urandom_range(1024)) - 16'd512;
    endcase
  endfunction

  // Offer one point item, idling first at the current rate; predict on accept.
  task automatic send_point(point_t p, bit typed, result_t want);
    result_q_t predicted;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      point <= point_t'({$urandom, 1'($urandom)});
      @(posedge clk);
    end
    start <= 1'b1;
    point <= p;
    // busy sampled here is the value before the edge
    do @(posedge clk); while (busy);
    predicted = fold_point(p);
    items_sent++;
    if (p.last_point) sets_closed++;
    if (typed) owe_result(want);
    else foreach (predicted[j]) owe_result(predicted[j]);
  endtask

  // Hold start low until every owed result is in and the pipe has drained.
  task automatic settle();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register while the block is idle and track it in the shadow.
  task automatic program_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_QUERY_X:    query_x_q = data;
      CFG_QUERY_Y:    query_y_q = data;
      CFG_KEEP_COUNT: keep_q = data[KEEP_W-1:0];
      default:        ;
    endcase
  endtask

  // Compare every result with the oldest expectation; results cannot be held off.
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("unexpected result: distance %0d point_index %0d last_result %0d",
               result.distance, result.point_index, result.last_result);
        fail_count++;
      end else begin
        oldest = expected_results.pop_front();
        if (result.distance !== oldest.distance) begin
          $error("distance: expected %0d, got %0d", oldest.distance, result.distance);
          fail_count++;
        end
        if (result.point_index !== oldest.point_index) begin
          $error("point_index: expected %0d, got %0d",
                 oldest.point_index, result.point_index);
          fail_count++;
        end
        if (result.last_result !== oldest.last_result) begin
          $error("last_result: expected %0d, got %0d",
                 oldest.last_result, result.last_result);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int     mode, in_mode, len, mid, n;
    point_t p;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table with a light idle rate.
    idle_pct = 32;
    foreach (drill[r]) begin
      if (drill[r].kind == ROW_REG) program_reg(drill[r].reg_idx, drill[r].reg_data);
      else send_point(drill[r].pt, drill[r].typed, drill[r].want);
    end

    // Random sets: sender idles at 32 percent, then 69, then not at all.
    for (mode = 0; mode < 3; mode++) begin
      idle_pct = (mode == 0) ? 32 : ((mode == 1) ? 69 : 0);
      in_mode = 0;
      while (in_mode < ITEMS_PER_MODE) begin
        if ($urandom_range(2) == 0) begin
          program_reg(CFG_QUERY_X, pick_coord(CFG_W'($urandom)));
          program_reg(CFG_QUERY_Y, pick_coord(CFG_W'($urandom)));
          // upper data bits are random; only the low bits count
          program_reg(CFG_KEEP_COUNT, CFG_W'($urandom));
        end
        len = ($urandom_range(7) == 0) ? $urandom_range(24, 12) : $urandom_range(10, 1);
        // now and then change keep_count part way through the set
        mid = ($urandom_range(5) == 0) ? $urandom_range(len - 1) : 0;
        for (n = 0; n < len; n++) begin
          if (mid != 0 && n == mid) program_reg(CFG_KEEP_COUNT, CFG_W'($urandom));
          p.point_x = pick_coord(query_x_q);
          p.point_y = pick_coord(query_y_q);
          p.last_point = (n == len - 1);
          send_point(p, 1'b0, '0);
        end
        in_mode += len;
      end
    end

    settle();
    $display("Run covered %0d point items in %0d sets and checked %0d results,",
             items_sent, sets_closed, results_seen);
    $display("with tie order, keep_count clamping and mid-set keep_count changes exercised.");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #(LIMIT_CYCLES * 20);
    $display("Some tests failed");
    $finish;
  end

endmodule

/* k_nearest_point_select.f */
+incdir+rtl
rtl/knps_pkg.sv
rtl/knps_front.sv
rtl/knps_fifo.sv
rtl/knps_isqrt.sv
rtl/knps_back.sv
rtl/k_nearest_point_select.sv
tb/sv/tb.sv
